### rtl/gpx_pkg.sv
// gpx_pkg: shared types, constants and helpers for the GF(2) polynomial
// extended gcd unit. No dependencies; used by the datapath, sequencer and top level.
package gpx_pkg;

    // operand width used inside the datapath
    localparam int POLY_WIDTH = 16;
    // width of the payload fields at the ports
    localparam int FIELD_W = 16;
    // shift count width, holds up to POLY_WIDTH-1
    localparam int CNT_W = (POLY_WIDTH > 2) ? $clog2(POLY_WIDTH) : 1;

    typedef logic [POLY_WIDTH-1:0] poly_t;
    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // input item
    typedef struct packed {
        field_t poly_a;
        field_t poly_b;
    } gpx_in_t;

    // result item
    typedef struct packed {
        field_t gcd_poly;
        field_t coef_a;
        field_t coef_b;
    } gpx_out_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_ALIGN,
        ST_REDUCE,
        ST_DONE
    } gpx_state_t;

    // sequencer to datapath
    typedef struct packed {
        logic load;
        logic setup;
        logic align_shift;
        logic reduce;
    } gpx_ctrl_t;

    // datapath to sequencer
    typedef struct packed {
        logic r1_zero;
        logic align_more;
        logic cnt_zero;
    } gpx_stat_t;

    // port field to operand width, upper bits dropped or zero filled
    function automatic poly_t to_poly(input field_t f);
        poly_t p;
        p = '0;
        for (int i = 0; i < POLY_WIDTH; i++) begin
            if (i < FIELD_W) begin
                p[i] = f[i];
            end
        end
        return p;
    endfunction

    // operand width to port field
    function automatic field_t to_field(input poly_t p);
        field_t f;
        f = '0;
        for (int i = 0; i < FIELD_W; i++) begin
            if (i < POLY_WIDTH) begin
                f[i] = p[i];
            end
        end
        return f;
    endfunction

endpackage

### rtl/gpx_datapath.sv
// gpx_datapath: remainder and Bezout coefficient registers with the
// one-bit-per-cycle divisor shift registers. Depends on gpx_pkg.
module gpx_datapath (
    input  logic              clk,
    input  gpx_pkg::gpx_in_t  operands,
    input  gpx_pkg::gpx_ctrl_t ctrl,
    output gpx_pkg::gpx_stat_t stat,
    output gpx_pkg::gpx_out_t result
);

    gpx_pkg::poly_t r0_reg, r0_next, r1_reg, r1_next;
    gpx_pkg::poly_t s0_reg, s0_next, s1_reg, s1_next;
    gpx_pkg::poly_t t0_reg, t0_next, t1_reg, t1_next;
    gpx_pkg::poly_t d_reg, d_next, sd_reg, sd_next, td_reg, td_next;
    gpx_pkg::cnt_t  cnt_reg, cnt_next;

    gpx_pkg::poly_t r0_red, s0_red, t0_red;
    logic           hit;

    // divisor degree matches remainder degree (divisor degree never lower)
    assign hit = ((r0_reg ^ d_reg) < r0_reg);

    // one quotient bit applied
    assign r0_red = hit ? (r0_reg ^ d_reg) : r0_reg;
    assign s0_red = hit ? (s0_reg ^ sd_reg) : s0_reg;
    assign t0_red = hit ? (t0_reg ^ td_reg) : t0_reg;

    // status for the sequencer
    assign stat.r1_zero    = (r1_reg == '0);
    assign stat.align_more = (d_reg < r0_reg) && (d_reg < (r0_reg ^ d_reg));
    assign stat.cnt_zero   = (cnt_reg == '0);

    // next values
    always_comb
    begin
        r0_next  = r0_reg;
        r1_next  = r1_reg;
        s0_next  = s0_reg;
        s1_next  = s1_reg;
        t0_next  = t0_reg;
        t1_next  = t1_reg;
        d_next   = d_reg;
        sd_next  = sd_reg;
        td_next  = td_reg;
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            r0_next = gpx_pkg::to_poly(operands.poly_a);
            r1_next = gpx_pkg::to_poly(operands.poly_b);
            s0_next = gpx_pkg::poly_t'(1);
            s1_next = '0;
            t0_next = '0;
            t1_next = gpx_pkg::poly_t'(1);
        end
        else if (ctrl.setup)
        begin
            d_next   = r1_reg;
            sd_next  = s1_reg;
            td_next  = t1_reg;
            cnt_next = '0;
        end
        else if (ctrl.align_shift)
        begin
            d_next   = d_reg << 1;
            sd_next  = sd_reg << 1;
            td_next  = td_reg << 1;
            cnt_next = cnt_reg + gpx_pkg::cnt_t'(1);
        end
        else if (ctrl.reduce)
        begin
            if (cnt_reg == '0)
            begin
                // division finished: rotate remainders and coefficients
                r0_next = r1_reg;
                r1_next = r0_red;
                s0_next = s1_reg;
                s1_next = s0_red;
                t0_next = t1_reg;
                t1_next = t0_red;
            end
            else
            begin
                r0_next  = r0_red;
                s0_next  = s0_red;
                t0_next  = t0_red;
                d_next   = d_reg >> 1;
                sd_next  = sd_reg >> 1;
                td_next  = td_reg >> 1;
                cnt_next = cnt_reg - gpx_pkg::cnt_t'(1);
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        r0_reg  <= r0_next;
        r1_reg  <= r1_next;
        s0_reg  <= s0_next;
        s1_reg  <= s1_next;
        t0_reg  <= t0_next;
        t1_reg  <= t1_next;
        d_reg   <= d_next;
        sd_reg  <= sd_next;
        td_reg  <= td_next;
        cnt_reg <= cnt_next;
    end

    // result comes straight from the working registers
    assign result.gcd_poly = gpx_pkg::to_field(r0_reg);
    assign result.coef_a   = gpx_pkg::to_field(s0_reg);
    assign result.coef_b   = gpx_pkg::to_field(t0_reg);

endmodule

### rtl/gpx_ctrl.sv
// gpx_ctrl: sequencer for load, alignment, reduction and result transfer.
// Depends on gpx_pkg.
module gpx_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  gpx_pkg::gpx_stat_t stat,
    output gpx_pkg::gpx_ctrl_t ctrl,
    output logic               busy,
    output logic               done
);

    gpx_pkg::gpx_state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gpx_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and controls
    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        busy       = 1'b1;
        done       = 1'b0;
        case (state_reg)
            gpx_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = gpx_pkg::ST_CHECK;
                end
            end
            gpx_pkg::ST_CHECK:
            begin
                if (stat.r1_zero)
                begin
                    state_next = gpx_pkg::ST_DONE;
                end
                else
                begin
                    ctrl.setup = 1'b1;
                    state_next = gpx_pkg::ST_ALIGN;
                end
            end
            gpx_pkg::ST_ALIGN:
            begin
                if (stat.align_more)
                begin
                    ctrl.align_shift = 1'b1;
                end
                else
                begin
                    state_next = gpx_pkg::ST_REDUCE;
                end
            end
            gpx_pkg::ST_REDUCE:
            begin
                ctrl.reduce = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = gpx_pkg::ST_CHECK;
                end
            end
            gpx_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = gpx_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = gpx_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/gf2_poly_extended_gcd_unit.sv
// One item at a time: busy stays high until the cycle after done, so the
// next start is taken in the cycle after the result strobe.
// The divisor shifts one bit per cycle during alignment and reduction, which sets the step count.
// rst_n clears the sequencer to idle; the data registers are not reset.
module gf2_poly_extended_gcd_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  gpx_pkg::gpx_in_t  operands,
    output logic              busy,
    output logic              done,
    output gpx_pkg::gpx_out_t result
);

    gpx_pkg::gpx_ctrl_t ctrl;
    gpx_pkg::gpx_stat_t stat;

    // sequencer
    gpx_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctrl  (ctrl),
        .busy  (busy),
        .done  (done)
    );

    // remainder and coefficient datapath
    gpx_datapath u_datapath (
        .clk      (clk),
        .operands (operands),
        .ctrl     (ctrl),
        .stat     (stat),
        .result   (result)
    );

endmodule

### rtl/gpx_checker.sv
// gpx_checker: port-level checks on the start/busy/done sequencing of the
// extended gcd unit, bound to the top level. Depends on the top level ports.
module gpx_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // an accepted transfer makes the unit busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transfer");

    // the result strobe lasts one cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // a result only shows while an item is in work
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without busy");

    // the unit is free right after the result transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("busy after result transfer");

endmodule

bind gf2_poly_extended_gcd_unit gpx_checker u_gpx_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

### sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking testbench for gf2_poly_extended_gcd_unit, the GF(2) extended gcd
// block. Depends on rtl/gpx_pkg.sv for the operand and result structs and on the unit's RTL.
module tb_top;

    localparam int HALF_PERIOD = 5;
    localparam int RESET_CYCLES = 10;
    // tail run after every expected result is back
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    gpx_pkg::gpx_in_t operands = '0;
    logic busy;
    logic done;
    gpx_pkg::gpx_out_t result;

    gpx_pkg::gpx_out_t gcd_expected[$];
    int error_count = 0;
    int transfers_sent = 0;
    int results_checked = 0;
    int cycle_count = 0;

    gf2_poly_extended_gcd_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operands (operands),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // degree of a polynomial, -1 for zero
    function automatic int poly_degree(input logic [31:0] p);
        for (int k = 31; k >= 0; k--)
        begin
            if (p[k])
                return k;
        end
        return -1;
    endfunction

    // carry-less product, full width
    function automatic logic [31:0] carryless_mul(input gpx_pkg::poly_t x,
                                                  input gpx_pkg::poly_t y);
        logic [31:0] acc;
        acc = '0;
        for (int k = 0; k < gpx_pkg::POLY_WIDTH; k++)
        begin
            if (y[k])
                acc ^= 32'(x) << k;
        end
        return acc;
    endfunction

    // quotient of long division by xor-shift, den nonzero
    function automatic gpx_pkg::poly_t gf2_quotient(input gpx_pkg::poly_t num,
                                                    input gpx_pkg::poly_t den);
        gpx_pkg::poly_t q;
        gpx_pkg::poly_t rem;
        int dd;
        int dr;
        int sh;
        q = '0;
        rem = num;
        dd = poly_degree(32'(den));
        dr = poly_degree(32'(rem));
        while (dr >= dd)
        begin
            sh = dr - dd;
            q[sh] = 1'b1;
            rem ^= den << sh;
            dr = poly_degree(32'(rem));
        end
        return q;
    endfunction

    // iterative euclid with bezout coefficient tracking
    function automatic gpx_pkg::gpx_out_t predict_egcd(input gpx_pkg::gpx_in_t op);
        gpx_pkg::poly_t r0, r1, s0, s1, t0, t1;
        gpx_pkg::poly_t q, nr, ns, nt;
        gpx_pkg::gpx_out_t res;
        r0 = op.poly_a;
        r1 = op.poly_b;
        s0 = gpx_pkg::poly_t'(1);
        s1 = '0;
        t0 = '0;
        t1 = gpx_pkg::poly_t'(1);
        while (r1 != '0)
        begin
            q = gf2_quotient(r0, r1);
            nr = r0 ^ gpx_pkg::poly_t'(carryless_mul(q, r1));
            ns = s0 ^ gpx_pkg::poly_t'(carryless_mul(q, s1));
            nt = t0 ^ gpx_pkg::poly_t'(carryless_mul(q, t1));
            r0 = r1;
            r1 = nr;
            s0 = s1;
            s1 = ns;
            t0 = t1;
            t1 = nt;
        end
        res.gcd_poly = r0;
        res.coef_a = s0;
        res.coef_b = t0;
        return res;
    endfunction

    // random polynomial of exact degree d, zero for d < 0
    function automatic gpx_pkg::field_t random_poly_of_degree(input int d);
        logic [31:0] low_mask;
        if (d < 0)
            return '0;
        low_mask = (32'd1 << d) - 1;
        return gpx_pkg::field_t'(($urandom & low_mask) | (32'd1 << d));
    endfunction

    // idle gap before the next transfer, mostly short with the odd long one
    function automatic int pick_idle_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 9)
            return 0;
        else if (r < 17)
            return $urandom_range(1, 4);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input gpx_pkg::field_t got,
                                   input gpx_pkg::field_t want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        error_count++;
    endtask

    // one operand transfer, then an optional idle gap with start low
    task automatic send_operands(input gpx_pkg::field_t a, input gpx_pkg::field_t b,
                                 input int gap);
        gpx_pkg::gpx_in_t item;
        item.poly_a = a;
        item.poly_b = b;
        start <= 1'b1;
        operands <= item;
        do
            @(posedge clk);
        while (busy);
        gcd_expected.push_back(predict_egcd(item));
        transfers_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off until every expected result is back, plus a tail
    task automatic wait_for_results();
        start <= 1'b0;
        while (gcd_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // corner operands: zeros, all ones, single top or bottom bit, exact divisors
    task automatic test_directed();
        gpx_pkg::field_t dir_a[20] = '{16'h0000, 16'hABCD, 16'h0000, 16'hFFFF, 16'h0000,
                                       16'h0001, 16'hFFFF, 16'h8000, 16'h8000, 16'h0001,
                                       16'hFFFF, 16'h0001, 16'h8000, 16'hFFFF, 16'hAAAA,
                                       16'h5555, 16'h0006, 16'h0003, 16'h8001, 16'hC3A5};
        gpx_pkg::field_t dir_b[20] = '{16'h0000, 16'h0000, 16'hABCD, 16'h0000, 16'hFFFF,
                                       16'h0001, 16'hFFFF, 16'h8000, 16'h0001, 16'h8000,
                                       16'h0001, 16'hFFFF, 16'hFFFF, 16'h8000, 16'h5555,
                                       16'hAAAA, 16'h0003, 16'h0006, 16'h0003, 16'h0007};
        for (int i = 0; i < 20; i++)
            send_operands(dir_a[i], dir_b[i], pick_idle_gap());
    endtask

    // random operands of mixed shape
    task automatic test_random_operands(input int count);
        gpx_pkg::field_t a;
        gpx_pkg::field_t b;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 5))
                0, 1:
                begin
                    a = gpx_pkg::field_t'($urandom);
                    b = gpx_pkg::field_t'($urandom);
                end
                2:
                begin
                    a = random_poly_of_degree($urandom_range(0, 5));
                    b = random_poly_of_degree($urandom_range(0, 5));
                end
                3:
                begin
                    a = random_poly_of_degree(15);
                    b = random_poly_of_degree($urandom_range(12, 15));
                end
                4:
                begin
                    a = random_poly_of_degree($urandom_range(0, 6));
                    b = random_poly_of_degree($urandom_range(10, 15));
                end
                default:
                begin
                    // one operand zero
                    a = gpx_pkg::field_t'($urandom);
                    b = '0;
                    if ($urandom_range(0, 1))
                    begin
                        b = a;
                        a = '0;
                    end
                end
            endcase
            send_operands(a, b, pick_idle_gap());
        end
    endtask

    // operands built over a common nontrivial factor so the gcd is not one
    task automatic test_shared_factor(input int count);
        int dg;
        gpx_pkg::field_t g;
        gpx_pkg::field_t a;
        gpx_pkg::field_t b;
        for (int i = 0; i < count; i++)
        begin
            dg = $urandom_range(1, 8);
            g = random_poly_of_degree(dg);
            a = gpx_pkg::field_t'(carryless_mul(g,
                    random_poly_of_degree($urandom_range(0, 15 - dg))));
            b = gpx_pkg::field_t'(carryless_mul(g,
                    random_poly_of_degree($urandom_range(0, 15 - dg))));
            send_operands(a, b, pick_idle_gap());
        end
    endtask

    // start held high the whole time, no idle cycles
    task automatic test_back_to_back(input int count);
        for (int i = 0; i < count; i++)
            send_operands(gpx_pkg::field_t'($urandom), gpx_pkg::field_t'($urandom), 0);
    endtask

    // result check against the oldest expectation
    always @(posedge clk)
    begin : result_check
        gpx_pkg::gpx_out_t want;
        if (rst_n && done)
        begin
            if (gcd_expected.size() == 0)
            begin
                report_mismatch("unexpected result gcd", result.gcd_poly, '0);
            end
            else
            begin
                want = gcd_expected.pop_front();
                if (result.gcd_poly !== want.gcd_poly)
                    report_mismatch("gcd_poly", result.gcd_poly, want.gcd_poly);
                if (result.coef_a !== want.coef_a)
                    report_mismatch("coef_a", result.coef_a, want.coef_a);
                if (result.coef_b !== want.coef_b)
                    report_mismatch("coef_b", result.coef_b, want.coef_b);
                results_checked++;
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped at cycle limit with %0d results outstanding",
                     gcd_expected.size());
            $display("FAIL gf2_poly_extended_gcd_unit");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_for_results();
        test_random_operands(900);
        wait_for_results();
        test_shared_factor(650);
        wait_for_results();
        test_back_to_back(380);
        wait_for_results();

        $display("covered %0d transfers: corners, mixed random, shared-factor, back-to-back",
                 transfers_sent);
        $display("%0d results checked, %0d mismatches", results_checked, error_count);
        if (error_count == 0)
            $display("PASS gf2_poly_extended_gcd_unit");
        else
            $display("FAIL gf2_poly_extended_gcd_unit");
        $finish;
    end

endmodule
